>>> sv/obex_packet_parser_core_assert.svh
// assertion macros for the obex packet parser core
`ifndef OBEX_PACKET_PARSER_CORE_ASSERT_SVH
`define OBEX_PACKET_PARSER_CORE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define OPPC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define OPPC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/oppc_pkg.sv
// shared types and constants of the obex packet parser
package oppc_pkg;

    localparam logic [7:0] OPC_CONNECT = 8'h80;
    localparam logic [7:0] OPC_SETPATH = 8'h85;

    localparam logic [1:0] ST_INCOMPLETE = 2'd0;
    localparam logic [1:0] ST_COMPLETE   = 2'd1;
    localparam logic [1:0] ST_OVERRUN    = 2'd2;
    localparam logic [1:0] ST_INVALID    = 2'd3;

    localparam logic REG_PARSE_MODE   = 1'b0;
    localparam logic REG_RESP_OPCODE  = 1'b1;

    localparam int   PARAM_BYTES      = 6;
    localparam logic [15:0] HDR_PREFIX_LEN = 16'd3;
    localparam logic [15:0] RESET_PKT_LEN  = 16'd3;

    typedef struct packed {
        logic       parse_mode;
        logic [7:0] response_for_opcode;
    } cfg_t;

    typedef struct packed {
        logic [1:0]  parse_status;
        logic        value_valid;
        logic [7:0]  header_ident;
        logic [15:0] value_length;
        logic [15:0] value_offset;
        logic [7:0]  value_byte;
        logic [7:0]  op_code;
        logic [7:0]  resp_code;
        logic [7:0]  version_number;
        logic [7:0]  op_flags;
        logic [15:0] max_packet_len;
    } res_t;

endpackage

>>> sv/oppc_cfg_regs.sv
// apb configuration registers of the obex packet parser
module oppc_cfg_regs
    import oppc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output cfg_t        cfg
);

    cfg_t cfg_reg;
    logic wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign cfg    = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (wr_en) begin
            unique case (paddr[2])
                REG_PARSE_MODE:  cfg_reg.parse_mode <= pwdata[0];
                REG_RESP_OPCODE: cfg_reg.response_for_opcode <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_PARSE_MODE:  prdata = {31'd0, cfg_reg.parse_mode};
            REG_RESP_OPCODE: prdata = {24'd0, cfg_reg.response_for_opcode};
            default:         prdata = '0;
        endcase
    end

endmodule

>>> sv/oppc_engine.sv
// per-byte parse state machine and result register
module oppc_engine
    import oppc_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  cfg_t       cfg,
    input  logic       adv,
    input  logic [7:0] data_byte,
    input  logic       start_packet,
    output res_t       res
);

    typedef enum logic [3:0] {
        PH_OPCODE, PH_RESPCODE, PH_PKTLEN, PH_PARAMS, PH_HDR_ID, PH_HLEN_HI,
        PH_HLEN_LO, PH_HVALUE, PH_COMPLETE, PH_OVERRUN, PH_INVALID
    } phase_t;

    typedef struct packed {
        phase_t                       phase;
        logic [7:0]                   opcode;
        logic [7:0]                   resp;
        logic [PARAM_BYTES-1:0][7:0]  params;
        logic [7:0]                   cur_hdr;
        logic [15:0]                  field_len;
        logic [15:0]                  field_pos;
        logic [15:0]                  pkt_len;
        logic [15:0]                  pkt_pos;
    } state_t;

    state_t state_reg, state_next, cur, rst_st;
    res_t   res_reg, res_next;
    logic [15:0] fl, fp_inc;

    // state after a start of packet, taken from the current config
    always_comb begin
        rst_st         = '0;
        rst_st.pkt_len = RESET_PKT_LEN;
        if (cfg.parse_mode) begin
            rst_st.phase  = PH_RESPCODE;
            rst_st.opcode = cfg.response_for_opcode;
        end else begin
            rst_st.phase  = PH_OPCODE;
            rst_st.opcode = '0;
        end
    end

    always_comb begin
        fl         = '0;
        cur        = start_packet ? rst_st : state_reg;
        state_next = cur;
        res_next   = '0;
        fp_inc     = cur.field_pos + 16'd1;

        unique case (cur.phase)
            PH_OPCODE: begin
                state_next.opcode = data_byte;
                fl = (data_byte == OPC_SETPATH) ? 16'd4 :
                     (data_byte == OPC_CONNECT) ? 16'd6 : 16'd2;
                state_next.field_len = fl;
                state_next.pkt_len   = fl + 16'd1;
                state_next.phase     = PH_PKTLEN;
            end
            PH_RESPCODE: begin
                state_next.resp = data_byte;
                fl = (cur.opcode == OPC_CONNECT) ? 16'd6 : 16'd2;
                state_next.field_len = fl;
                state_next.pkt_len   = fl + 16'd1;
                state_next.phase     = PH_PKTLEN;
            end
            PH_PKTLEN, PH_PARAMS: begin
                for (int i = 0; i < PARAM_BYTES; i++) begin
                    if (cur.field_pos == 16'(i)) state_next.params[i] = data_byte;
                end
                state_next.field_pos = fp_inc;
                if (cur.phase == PH_PKTLEN) begin
                    if (fp_inc == 16'd2) begin
                        state_next.pkt_len = {state_next.params[0], state_next.params[1]};
                        if ({1'b0, state_next.pkt_len} < ({1'b0, cur.field_len} + 17'd1))
                            state_next.phase = PH_INVALID;
                        else if (cur.field_len == 16'd2)
                            state_next.phase = PH_HDR_ID;
                        else
                            state_next.phase = PH_PARAMS;
                    end
                end else if (fp_inc >= cur.field_len) begin
                    state_next.phase = PH_HDR_ID;
                end
            end
            PH_HDR_ID: begin
                state_next.cur_hdr   = data_byte;
                state_next.field_pos = '0;
                unique case (data_byte[7:6])
                    2'd0, 2'd1: begin
                        state_next.field_len = 16'd2;
                        state_next.phase     = PH_HLEN_HI;
                    end
                    2'd2: begin
                        state_next.field_len = 16'd1;
                        state_next.phase     = PH_HVALUE;
                    end
                    default: begin
                        state_next.field_len = 16'd4;
                        state_next.phase     = PH_HVALUE;
                    end
                endcase
            end
            PH_HLEN_HI: begin
                state_next.field_len = {data_byte, 8'd0};
                state_next.phase     = PH_HLEN_LO;
            end
            PH_HLEN_LO: begin
                fl = {cur.field_len[15:8], data_byte};
                state_next.field_len = fl;
                if (fl < HDR_PREFIX_LEN) begin
                    state_next.phase = PH_INVALID;
                end else if (fl == HDR_PREFIX_LEN) begin
                    state_next.phase = PH_HDR_ID;
                end else begin
                    state_next.field_len = fl - HDR_PREFIX_LEN;
                    state_next.phase     = PH_HVALUE;
                end
            end
            PH_HVALUE: begin
                res_next.value_valid  = 1'b1;
                res_next.header_ident = cur.cur_hdr;
                res_next.value_length = cur.field_len;
                res_next.value_offset = cur.field_pos;
                res_next.value_byte   = data_byte;
                state_next.field_pos  = fp_inc;
                if (fp_inc >= cur.field_len) state_next.phase = PH_HDR_ID;
            end
            PH_COMPLETE: state_next.phase = PH_OVERRUN;
            PH_OVERRUN:  state_next.phase = PH_OVERRUN;
            default:     state_next.phase = PH_INVALID;
        endcase

        // end of packet check
        state_next.pkt_pos = cur.pkt_pos + 16'd1;
        if (state_next.pkt_pos == state_next.pkt_len)
            state_next.phase = (state_next.phase == PH_HDR_ID) ? PH_COMPLETE : PH_INVALID;

        unique case (state_next.phase)
            PH_COMPLETE: res_next.parse_status = ST_COMPLETE;
            PH_OVERRUN:  res_next.parse_status = ST_OVERRUN;
            PH_INVALID:  res_next.parse_status = ST_INVALID;
            default:     res_next.parse_status = ST_INCOMPLETE;
        endcase

        res_next.op_code   = state_next.opcode;
        res_next.resp_code = state_next.resp;
        if (state_next.opcode == OPC_CONNECT) begin
            res_next.version_number = state_next.params[2];
            res_next.op_flags       = state_next.params[3];
            res_next.max_packet_len = {state_next.params[4], state_next.params[5]};
        end else if (state_next.opcode == OPC_SETPATH) begin
            res_next.op_flags = state_next.params[2];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= '0;
            state_reg.phase   <= PH_OPCODE;
            state_reg.pkt_len <= RESET_PKT_LEN;
        end else if (adv) begin
            state_reg <= state_next;
            res_reg   <= res_next;
        end
    end

    assign res = res_reg;

endmodule

>>> sv/obex_packet_parser_core.sv
// top level of the obex packet parser core
//
//  channel  | dir | transfer content
//  ---------+-----+------------------------------------------------
//  s_       | in  | one packet byte, tuser marks start of packet
//  m_       | out | one parse result per byte, tuser marks value byte
//  apb      | in  | parse_mode at 0x0, response_for_opcode at 0x4
//
// one byte per cycle sustained while the m_ side takes results; a byte passes
// the input register, then the parse state machine writes the result register
// throughput is set by the state update loop in the engine
// reset is synchronous and active low, clears config and parse state
// a stalled m_ side holds the result; the input register still takes one
// more byte, then s_tready drops until the result is taken
module obex_packet_parser_core
    import oppc_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    // input stream
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // [7:0] data_byte
    input  logic         s_tuser,   // [0] start_packet
    // result stream
    output logic         m_tvalid,
    input  logic         m_tready,
    // [1:0] parse_status, [9:2] header_ident, [25:10] value_length,
    // [41:26] value_offset, [49:42] value_byte, [57:50] op_code,
    // [65:58] resp_code, [73:66] version_number, [81:74] op_flags,
    // [97:82] max_packet_len, [103:98] zero
    output logic [103:0] m_tdata,
    output logic         m_tuser,   // [0] value_valid
    // configuration
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    cfg_t       cfg;
    res_t       res;
    logic       in_vld_reg;
    logic [7:0] in_byte_reg;
    logic       in_start_reg;
    logic       m_vld_reg;
    logic       out_ready;
    logic       adv;

    oppc_cfg_regs u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // result register is free when empty or being taken this cycle
    assign out_ready = !m_vld_reg || m_tready;
    // byte moves from input register through the parser into the result
    assign adv       = in_vld_reg && out_ready;
    assign s_tready  = !in_vld_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
            m_vld_reg  <= 1'b0;
        end else begin
            if (out_ready) m_vld_reg <= in_vld_reg;
            if (s_tready) begin
                in_vld_reg   <= s_tvalid;
                in_byte_reg  <= s_tdata;
                in_start_reg <= s_tuser;
            end
        end
    end

    oppc_engine u_engine (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg          (cfg),
        .adv          (adv),
        .data_byte    (in_byte_reg),
        .start_packet (in_start_reg),
        .res          (res)
    );

    assign m_tvalid = m_vld_reg;
    assign m_tuser  = res.value_valid;
    assign m_tdata  = {6'd0, res.max_packet_len, res.op_flags, res.version_number,
                       res.resp_code, res.op_code, res.value_byte, res.value_offset,
                       res.value_length, res.header_ident, res.parse_status};

    `include "obex_packet_parser_core_assert.svh"

    // a value byte always lies inside its header value
    `OPPC_ASSERT_NOW(a_offset_in_range, m_vld_reg && res.value_valid,
        res.value_offset < res.value_length, "value offset beyond value length")

    // overrun bytes never carry header values
    `OPPC_ASSERT_NOW(a_no_value_on_overrun, m_vld_reg && res.value_valid,
        res.parse_status != ST_OVERRUN, "value byte reported after completion")

    // fixed parameters only show for connect and setpath
    `OPPC_ASSERT_NOW(a_params_by_opcode,
        m_vld_reg && res.op_code != OPC_CONNECT && res.op_code != OPC_SETPATH,
        res.version_number == 8'd0 && res.op_flags == 8'd0 && res.max_packet_len == 16'd0,
        "parameters reported for an opcode without them")

    // a byte waiting in the input register is not dropped while blocked
    `OPPC_ASSERT_NEXT(a_input_held, in_vld_reg && !out_ready,
        in_vld_reg, "buffered byte lost while output stalled")

endmodule

>>> tb/tb.sv
// self-checking testbench for the obex packet parser core
`timescale 1ns / 1ps

module tb;
    import oppc_pkg::*;

    // clock, reset and run limits
    localparam int    CLK_HALF_NS   = 4;
    localparam int    RESET_CYCLES  = 12;
    localparam int    DRAIN_CYCLES  = 6;      // margin after the input and result registers
    localparam int    CYCLE_LIMIT   = 200_000;
    localparam int    MAX_WAIT      = 10;
    localparam int    HOLD_CYCLES   = 300;
    localparam int    HOLD_AT_FIRST = 60;     // lands early in the random part
    localparam int    HOLD_AT_NEXT  = 300;    // lands later in the random part
    localparam int    RAND_PHASES   = 8;
    localparam int    PHASE_ITEMS   = 95;

    // register addresses, one word apart
    localparam logic [2:0] ADDR_MODE    = 3'(4 * REG_PARSE_MODE);
    localparam logic [2:0] ADDR_RESP_OP = 3'(4 * REG_RESP_OPCODE);

    // parser phases as tracked by the prediction
    typedef enum logic [3:0] {
        P_WAIT_OP, P_WAIT_RESP, P_LEN, P_PARAM, P_HID, P_HLEN_H, P_HLEN_L,
        P_HVAL, P_DONE, P_OVER, P_BAD
    } parse_phase_e;

    // ways a random packet can be broken
    typedef enum int {
        FLAW_NONE, FLAW_PKT_LEN, FLAW_HDR_LEN, FLAW_TRAILING, FLAW_TRUNCATE
    } packet_flaw_e;

    typedef struct {
        logic [7:0] data;
        logic       sop;
    } pkt_byte_t;

    // dut ports
    logic         aclk     = 1'b0;
    logic         aresetn  = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [7:0]   s_tdata  = '0;
    logic         s_tuser  = 1'b0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [103:0] m_tdata;
    logic         m_tuser;
    logic         psel     = 1'b0;
    logic         penable  = 1'b0;
    logic         pwrite   = 1'b0;
    logic [2:0]   paddr    = '0;
    logic [31:0]  pwdata   = '0;
    logic [31:0]  prdata;
    logic         pready;

    obex_packet_parser_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // bytes waiting to be sent and parse results waiting to arrive
    pkt_byte_t    pending_bytes[$];
    res_t         expected_results[$];

    // configuration as last written, and the predicted parser state
    cfg_t         cfg_now = '0;
    parse_phase_e ph      = P_WAIT_OP;
    logic [7:0]   opc     = '0;
    logic [7:0]   rsp     = '0;
    logic [7:0]   prm [PARAM_BYTES];
    logic [7:0]   hdr     = '0;
    logic [15:0]  flen    = '0;
    logic [15:0]  fpos    = '0;
    logic [15:0]  plen    = RESET_PKT_LEN;
    logic [15:0]  ppos    = '0;

    // run control shared between processes
    bit           no_idle      = 1'b0;
    int           fail_count   = 0;
    int           results_seen = 0;
    int           hold_left    = 0;
    int           holds_done   = 0;
    int           cycle_count  = 0;
    int           send_gap     = 0;
    int           recv_gap     = 0;

    initial begin
        forever #(CLK_HALF_NS) aclk = ~aclk;
    end

    // back to the start of a packet, taking mode and opcode from the registers
    task automatic restart_parser();
        foreach (prm[i]) prm[i] = '0;
        rsp  = '0;
        hdr  = '0;
        flen = '0;
        fpos = '0;
        plen = RESET_PKT_LEN;
        ppos = '0;
        if (cfg_now.parse_mode) begin
            ph  = P_WAIT_RESP;
            opc = cfg_now.response_for_opcode;
        end else begin
            ph  = P_WAIT_OP;
            opc = '0;
        end
    endtask

    // advance the parser by one byte and work out the result it gives
    task automatic parse_byte(input logic [7:0] b, input logic sop, output res_t r);
        r = '0;
        if (sop) restart_parser();
        case (ph)
            P_WAIT_OP: begin
                opc  = b;
                flen = (b == OPC_SETPATH) ? 16'd4 : (b == OPC_CONNECT) ? 16'd6 : 16'd2;
                plen = flen + 16'd1;
                ph   = P_LEN;
            end
            P_WAIT_RESP: begin
                rsp  = b;
                flen = (opc == OPC_CONNECT) ? 16'd6 : 16'd2;
                plen = flen + 16'd1;
                ph   = P_LEN;
            end
            P_LEN: begin
                if (fpos < PARAM_BYTES) prm[fpos[2:0]] = b;
                fpos++;
                if (fpos == 16'd2) begin
                    plen = {prm[0], prm[1]};
                    if (plen < flen + 16'd1) ph = P_BAD;
                    else if (flen == 16'd2) ph = P_HID;
                    else ph = P_PARAM;
                end
            end
            P_PARAM: begin
                if (fpos < PARAM_BYTES) prm[fpos[2:0]] = b;
                fpos++;
                if (fpos >= flen) ph = P_HID;
            end
            P_HID: begin
                hdr  = b;
                fpos = '0;
                case (b[7:6])
                    2'd0, 2'd1: begin
                        flen = 16'd2;
                        ph   = P_HLEN_H;
                    end
                    2'd2: begin
                        flen = 16'd1;
                        ph   = P_HVAL;
                    end
                    default: begin
                        flen = 16'd4;
                        ph   = P_HVAL;
                    end
                endcase
            end
            P_HLEN_H: begin
                flen = {b, 8'h00};
                ph   = P_HLEN_L;
            end
            P_HLEN_L: begin
                flen = flen | {8'h00, b};
                if (flen < HDR_PREFIX_LEN) begin
                    ph = P_BAD;
                end else if (flen == HDR_PREFIX_LEN) begin
                    ph = P_HID;
                end else begin
                    flen = flen - HDR_PREFIX_LEN;
                    ph   = P_HVAL;
                end
            end
            P_HVAL: begin
                r.value_valid  = 1'b1;
                r.header_ident = hdr;
                r.value_length = flen;
                r.value_offset = fpos;
                r.value_byte   = b;
                fpos++;
                if (fpos >= flen) ph = P_HID;
            end
            P_DONE:  ph = P_OVER;
            P_OVER:  ;
            default: ph = P_BAD;
        endcase

        // end of packet only counts as complete between headers
        ppos++;
        if (ppos == plen) ph = (ph == P_HID) ? P_DONE : P_BAD;

        case (ph)
            P_DONE:  r.parse_status = ST_COMPLETE;
            P_OVER:  r.parse_status = ST_OVERRUN;
            P_BAD:   r.parse_status = ST_INVALID;
            default: r.parse_status = ST_INCOMPLETE;
        endcase

        r.op_code   = opc;
        r.resp_code = rsp;
        if (opc == OPC_CONNECT) begin
            r.version_number = prm[2];
            r.op_flags       = prm[3];
            r.max_packet_len = {prm[4], prm[5]};
        end else if (opc == OPC_SETPATH) begin
            r.op_flags = prm[2];
        end
    endtask

    // report one field that differs
    task automatic cmp_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0h, actual %0h", name, want, got);
            fail_count++;
        end
    endtask

    task automatic push_byte(input logic [7:0] data, input logic sop);
        pending_bytes.push_back('{data: data, sop: sop});
    endtask

    // a run of bytes, start of packet flagged on the first one only
    task automatic queue_bytes(input logic [7:0] seq[$], input logic sop_first);
        foreach (seq[i]) push_byte(seq[i], sop_first && (i == 0));
    endtask

    // apb write: setup cycle, then access cycle until pready
    task automatic cfg_write(input logic [2:0] addr, input logic [31:0] data);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == ADDR_MODE) cfg_now.parse_mode = data[0];
        else cfg_now.response_for_opcode = data[7:0];
    endtask

    // nothing left to send or to receive, plus DRAIN_CYCLES of margin
    task automatic wait_drained();
        while (pending_bytes.size() != 0 || expected_results.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // one packet with random content, well formed unless a flaw is asked for
    task automatic queue_packet(input packet_flaw_e flaw);
        logic [7:0]  pkt[$];
        logic [7:0]  op;
        logic [7:0]  hid;
        logic [15:0] hlen;
        logic [15:0] len_field;
        int          n_par;
        int          n_hdr;
        int          kind;
        int          vlen;
        int          total;
        pkt = {};
        if (cfg_now.parse_mode) begin
            op = cfg_now.response_for_opcode;
            pkt.push_back(8'($urandom_range(0, 255)));   // response code
            n_par = (op == OPC_CONNECT) ? 4 : 0;
        end else begin
            case ($urandom_range(0, 3))
                0:       op = OPC_CONNECT;
                1:       op = OPC_SETPATH;
                default: op = 8'($urandom_range(0, 255));
            endcase
            pkt.push_back(op);
            n_par = (op == OPC_CONNECT) ? 4 : (op == OPC_SETPATH) ? 2 : 0;
        end
        pkt.push_back(8'h00);   // length, filled in below
        pkt.push_back(8'h00);
        repeat (n_par) pkt.push_back(8'($urandom_range(0, 255)));

        n_hdr = $urandom_range(0, 4);
        repeat (n_hdr) begin
            kind = $urandom_range(0, 3);
            hid  = {kind[1:0], 6'($urandom_range(0, 63))};
            pkt.push_back(hid);
            if (kind < 2) begin
                // length counts the three prefix bytes; zero-length values now and then
                vlen = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                hlen = 16'(vlen + 3);
                if (flaw == FLAW_HDR_LEN) hlen = 16'($urandom_range(0, 2));
                pkt.push_back(hlen[15:8]);
                pkt.push_back(hlen[7:0]);
            end else begin
                vlen = (kind == 2) ? 1 : 4;
            end
            repeat (vlen) pkt.push_back(8'($urandom_range(0, 255)));
        end

        total     = pkt.size();
        len_field = 16'(total);
        case (flaw)
            FLAW_PKT_LEN: begin
                if ($urandom_range(0, 1)) len_field = 16'($urandom_range(0, total - 1));
                else len_field = 16'(total + $urandom_range(1, 6));
            end
            FLAW_TRAILING: repeat ($urandom_range(1, 3)) pkt.push_back(8'($urandom_range(0, 255)));
            FLAW_TRUNCATE: repeat ($urandom_range(1, total - 1)) void'(pkt.pop_back());
            default: ;
        endcase
        if (pkt.size() > 1) pkt[1] = len_field[15:8];
        if (pkt.size() > 2) pkt[2] = len_field[7:0];
        queue_bytes(pkt, 1'b1);
    endtask

    // input side: offer the oldest pending byte, random gap after each transfer
    always @(posedge aclk) begin : byte_driver
        res_t   predicted;
        logic   took;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            send_gap = 0;
        end else begin
            took = s_tvalid && s_tready;
            if (took) begin
                parse_byte(pending_bytes[0].data, pending_bytes[0].sop, predicted);
                expected_results.push_back(predicted);
                void'(pending_bytes.pop_front());
                send_gap = no_idle ? 0 : $urandom_range(0, MAX_WAIT);
            end
            if (s_tvalid && !took) begin
                // hold the offered byte until it is taken
            end else if (send_gap > 0) begin
                send_gap--;
                s_tvalid <= 1'b0;
            end else if (pending_bytes.size() != 0) begin
                s_tvalid <= 1'b1;
                s_tdata  <= pending_bytes[0].data;
                s_tuser  <= pending_bytes[0].sop;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // long receiver hold-off so the input side backs up and stalls
    always @(posedge aclk) begin : rx_hold
        if (!aresetn) begin
            hold_left  <= 0;
            holds_done <= 0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (holds_done < 2 &&
                     results_seen >= ((holds_done == 0) ? HOLD_AT_FIRST : HOLD_AT_NEXT)) begin
            hold_left  <= HOLD_CYCLES;
            holds_done <= holds_done + 1;
        end
    end

    // result side: check every transfer against the oldest expectation
    always @(posedge aclk) begin : result_monitor
        res_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
            recv_gap = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_results.size() == 0) begin
                    $error("result transfer with no expectation waiting");
                    fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    cmp_field("parse_status",   16'(want.parse_status),   16'(m_tdata[1:0]));
                    cmp_field("value_valid",    16'(want.value_valid),    16'(m_tuser));
                    cmp_field("header_ident",   16'(want.header_ident),   16'(m_tdata[9:2]));
                    cmp_field("value_length",   want.value_length,        m_tdata[25:10]);
                    cmp_field("value_offset",   want.value_offset,        m_tdata[41:26]);
                    cmp_field("value_byte",     16'(want.value_byte),     16'(m_tdata[49:42]));
                    cmp_field("op_code",        16'(want.op_code),        16'(m_tdata[57:50]));
                    cmp_field("resp_code",      16'(want.resp_code),      16'(m_tdata[65:58]));
                    cmp_field("version_number", 16'(want.version_number), 16'(m_tdata[73:66]));
                    cmp_field("op_flags",       16'(want.op_flags),       16'(m_tdata[81:74]));
                    cmp_field("max_packet_len", want.max_packet_len,      m_tdata[97:82]);
                    cmp_field("tdata padding",  16'h0000,                 16'(m_tdata[103:98]));
                end
                results_seen <= results_seen + 1;
                recv_gap = no_idle ? 0 : $urandom_range(0, MAX_WAIT);
            end else if (recv_gap > 0) begin
                recv_gap--;
            end
            m_tready <= (recv_gap == 0) && (hold_left == 0);
        end
    end

    // watchdog on the whole run
    always @(posedge aclk) begin : watchdog
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("obex_packet_parser_core verification failed");
            $finish;
        end
    end

    // stimulus sequence
    initial begin : stimulus
        logic [7:0]   seq[$];
        packet_flaw_e flaw;
        int           target;
        foreach (prm[i]) prm[i] = '0;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed, request mode from reset
        // connect with all-ones flags and max packet length, ends complete
        seq = {8'h80, 8'h00, 8'h07, 8'h10, 8'hFF, 8'hFF, 8'hFF};
        queue_bytes(seq, 1'b1);
        // setpath whose packet length is below opcode plus parameters
        seq = {8'h85, 8'h00, 8'h03};
        queue_bytes(seq, 1'b1);
        // header length below the prefix size
        seq = {8'h02, 8'h00, 8'h09, 8'h41, 8'h00, 8'h02};
        queue_bytes(seq, 1'b1);
        // empty header value, then a four-byte header, ends complete
        seq = {8'h02, 8'h00, 8'h0B, 8'h01, 8'h00, 8'h03, 8'hC3, 8'h00, 8'hFF, 8'h00, 8'hFF};
        queue_bytes(seq, 1'b1);
        // minimal packet with all-ones opcode, then bytes past completion
        seq = {8'hFF, 8'h00, 8'h03};
        queue_bytes(seq, 1'b1);
        push_byte(8'h00, 1'b0);
        push_byte(8'hFF, 1'b0);
        wait_drained();

        // random phases over several register settings
        for (int p = 0; p < RAND_PHASES; p++) begin
            wait_drained();
            case (p)
                0: begin cfg_write(ADDR_MODE, 32'd1); cfg_write(ADDR_RESP_OP, 32'(OPC_CONNECT)); end
                1: begin cfg_write(ADDR_MODE, 32'd0); cfg_write(ADDR_RESP_OP, 32'hFF); end
                2: begin cfg_write(ADDR_MODE, 32'd1); cfg_write(ADDR_RESP_OP, 32'h00); end
                3: begin cfg_write(ADDR_MODE, 32'd1); cfg_write(ADDR_RESP_OP, 32'(OPC_SETPATH)); end
                4: begin cfg_write(ADDR_MODE, 32'd1); cfg_write(ADDR_RESP_OP, 32'hFF); end
                5: begin cfg_write(ADDR_MODE, 32'd0); cfg_write(ADDR_RESP_OP, 32'h00); end
                default: begin
                    cfg_write(ADDR_MODE, 32'($urandom_range(0, 1)));
                    cfg_write(ADDR_RESP_OP, $urandom_range(0, 1) ? 32'(OPC_CONNECT)
                                                                 : 32'($urandom_range(0, 255)));
                end
            endcase
            no_idle = (p % 3 == 2);
            // a write alone must not restart: this byte still runs in the old packet
            push_byte(8'($urandom_range(0, 255)), 1'b0);
            target = pending_bytes.size() + PHASE_ITEMS;
            while (pending_bytes.size() < target) begin
                if ($urandom_range(0, 9) == 0) begin
                    // noise, with stray start flags
                    repeat ($urandom_range(1, 3))
                        push_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
                end else begin
                    case ($urandom_range(0, 9))
                        0:       flaw = FLAW_PKT_LEN;
                        1:       flaw = FLAW_HDR_LEN;
                        2:       flaw = FLAW_TRAILING;
                        3:       flaw = FLAW_TRUNCATE;
                        default: flaw = FLAW_NONE;
                    endcase
                    queue_packet(flaw);
                end
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0)
            $display("obex_packet_parser_core verification clean");
        else
            $display("obex_packet_parser_core verification failed");
        $finish;
    end

endmodule
